@@ rtl/arrt_pkg.sv @@
// ----------------------------------------------------------------------------
// arrt_pkg
// Shared types and defaults of the address range region table.
// ----------------------------------------------------------------------------
package arrt_pkg;

    localparam int TABLE_DEPTH  = 16;
    localparam int ADDRESS_BITS = 48;
    localparam int HANDLE_BITS  = 16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISS    = 2'd1,
        ST_IGNORED = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_ADD,
        CMD_PURGE,
        CMD_COMPACT,
        CMD_FIND
    } t_cmd;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        t_cmd cmd;
        logic parity;
    } t_cell_ctl;

endpackage

@@ rtl/arrt_req_if.sv @@
// ----------------------------------------------------------------------------
// arrt_req_if
// Request channel of the region table: operation, handle, address, length.
// ----------------------------------------------------------------------------
interface arrt_req_if #(
    parameter int ADDRESS_BITS = arrt_pkg::ADDRESS_BITS,
    parameter int HANDLE_BITS  = arrt_pkg::HANDLE_BITS
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              operation;
    logic [HANDLE_BITS-1:0]  handle;
    logic [ADDRESS_BITS-1:0] address;
    logic [ADDRESS_BITS-1:0] length;

    modport source (output valid, operation, handle, address, length, input ready);
    modport sink   (input valid, operation, handle, address, length, output ready);
endinterface

@@ rtl/arrt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// arrt_rsp_if
// Response channel of the region table: status, found handle, found offset.
// ----------------------------------------------------------------------------
interface arrt_rsp_if #(
    parameter int ADDRESS_BITS = arrt_pkg::ADDRESS_BITS,
    parameter int HANDLE_BITS  = arrt_pkg::HANDLE_BITS
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [HANDLE_BITS-1:0]  found_handle;
    logic [ADDRESS_BITS-1:0] found_offset;

    modport source (output valid, status, found_handle, found_offset, input ready);
    modport sink   (input valid, status, found_handle, found_offset, output ready);
endinterface

@@ rtl/arrt_cell.sv @@
// ----------------------------------------------------------------------------
// arrt_cell
// One table slot: holds a region, appends, purges, compacts with its
// neighbors and forwards the first find hit toward slot zero.
// ----------------------------------------------------------------------------
module arrt_cell #(
    parameter int ADDRESS_BITS = arrt_pkg::ADDRESS_BITS,
    parameter int HANDLE_BITS  = arrt_pkg::HANDLE_BITS,
    parameter bit IDX_ODD      = 1'b0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  arrt_pkg::t_cell_ctl     i_ctl,
    input  logic [HANDLE_BITS-1:0]  i_hnd,
    input  logic [ADDRESS_BITS-1:0] i_addr,
    input  logic [ADDRESS_BITS-1:0] i_len,
    input  logic                    i_prev_valid,
    input  logic                    i_next_valid,
    input  logic [HANDLE_BITS-1:0]  i_next_handle,
    input  logic [ADDRESS_BITS-1:0] i_next_base,
    input  logic [ADDRESS_BITS-1:0] i_next_size,
    input  logic                    i_next_hit,
    input  logic [HANDLE_BITS-1:0]  i_next_hit_handle,
    input  logic [ADDRESS_BITS-1:0] i_next_hit_offset,
    output logic                    o_valid,
    output logic [HANDLE_BITS-1:0]  o_handle,
    output logic [ADDRESS_BITS-1:0] o_base,
    output logic [ADDRESS_BITS-1:0] o_size,
    output logic                    o_hit,
    output logic [HANDLE_BITS-1:0]  o_hit_handle,
    output logic [ADDRESS_BITS-1:0] o_hit_offset
);

    logic                    r_valid;
    logic [HANDLE_BITS-1:0]  r_handle;
    logic [ADDRESS_BITS-1:0] r_base;
    logic [ADDRESS_BITS-1:0] r_size;
    logic                    r_hit;
    logic [HANDLE_BITS-1:0]  r_hit_handle;
    logic [ADDRESS_BITS-1:0] r_hit_offset;

    logic [ADDRESS_BITS-1:0] w_off;
    logic [ADDRESS_BITS-1:0] w_room;
    logic                    w_hit;
    logic                    w_upper;

    assign w_off   = i_addr - r_base;
    assign w_room  = r_size - w_off;
    assign w_hit   = r_valid && (i_addr >= r_base) && (w_off <= r_size) && (i_len <= w_room);
    // upper slot of the pair being compacted this round
    assign w_upper = (i_ctl.parity == IDX_ODD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            unique case (i_ctl.cmd)
                arrt_pkg::CMD_ADD: begin
                    if (!r_valid && i_prev_valid) r_valid <= 1'b1;
                end
                arrt_pkg::CMD_PURGE: begin
                    if (r_valid && (r_handle == i_hnd)) r_valid <= 1'b0;
                end
                arrt_pkg::CMD_COMPACT: begin
                    if (w_upper) begin
                        if (!r_valid && i_next_valid) r_valid <= 1'b1;
                    end else if (!i_prev_valid && r_valid) begin
                        // entry moved up into the empty neighbor
                        r_valid <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == arrt_pkg::CMD_ADD && !r_valid && i_prev_valid) begin
            r_handle <= i_hnd;
            r_base   <= i_addr;
            r_size   <= i_len;
        end else if (i_ctl.cmd == arrt_pkg::CMD_COMPACT && w_upper && !r_valid
                     && i_next_valid) begin
            r_handle <= i_next_handle;
            r_base   <= i_next_base;
            r_size   <= i_next_size;
        end
    end

    // own hit wins over anything later in insertion order
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == arrt_pkg::CMD_FIND) begin
            r_hit        <= w_hit || i_next_hit;
            r_hit_handle <= w_hit ? r_handle : i_next_hit_handle;
            r_hit_offset <= w_hit ? w_off : i_next_hit_offset;
        end
    end

    assign o_valid      = r_valid;
    assign o_handle     = r_handle;
    assign o_base       = r_base;
    assign o_size       = r_size;
    assign o_hit        = r_hit;
    assign o_hit_handle = r_hit_handle;
    assign o_hit_offset = r_hit_offset;

endmodule

@@ rtl/address_range_region_table.sv @@
// ----------------------------------------------------------------------------
// address_range_region_table
// Insertion-ordered table of address regions with add, remove and find.
// ----------------------------------------------------------------------------
// One request is handled at a time. An add, an ignored request or a find with
// a null address goes from S_EXEC straight to S_RESP. A remove drops the
// matching entries in S_EXEC, then TABLE_DEPTH rounds of odd-even moves in
// S_COMPACT between neighboring cells close the gaps in order. A find runs
// through S_FIND and S_PICK: the first hit travels one cell per cycle down the
// chain to slot zero. A response can wait in the output register while the
// next request is taken. No clearing pass runs after reset; valid flags clear
// at once.
module address_range_region_table #(
    parameter int TABLE_DEPTH  = arrt_pkg::TABLE_DEPTH,
    parameter int ADDRESS_BITS = arrt_pkg::ADDRESS_BITS,
    parameter int HANDLE_BITS  = arrt_pkg::HANDLE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    arrt_req_if.sink   i_req,
    arrt_rsp_if.source o_rsp
);

    localparam int                 CW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CW-1:0]      LAST = CW'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_COMPACT,
        S_FIND,
        S_PICK,
        S_RESP
    } t_state;

    t_state                  r_state;
    logic [CW-1:0]           r_cnt;
    arrt_pkg::t_op           r_op;
    logic [HANDLE_BITS-1:0]  r_hnd;
    logic [ADDRESS_BITS-1:0] r_addr;
    logic [ADDRESS_BITS-1:0] r_len;
    arrt_pkg::t_status       r_res_status;
    logic [HANDLE_BITS-1:0]  r_res_handle;
    logic [ADDRESS_BITS-1:0] r_res_offset;
    logic                    r_rsp_valid;
    arrt_pkg::t_status       r_rsp_status;
    logic [HANDLE_BITS-1:0]  r_rsp_handle;
    logic [ADDRESS_BITS-1:0] r_rsp_offset;

    arrt_pkg::t_cell_ctl     w_ctl;
    logic                    w_null;
    logic                    w_full;

    logic                    w_valid      [TABLE_DEPTH];
    logic [HANDLE_BITS-1:0]  w_handle     [TABLE_DEPTH];
    logic [ADDRESS_BITS-1:0] w_base       [TABLE_DEPTH];
    logic [ADDRESS_BITS-1:0] w_size       [TABLE_DEPTH];
    logic                    w_hit        [TABLE_DEPTH];
    logic [HANDLE_BITS-1:0]  w_hit_handle [TABLE_DEPTH];
    logic [ADDRESS_BITS-1:0] w_hit_offset [TABLE_DEPTH];

    assign w_null = (r_hnd == '0) || (r_addr == '0) || (r_len == '0);
    assign w_full = w_valid[TABLE_DEPTH-1];

    always_comb begin
        w_ctl.cmd    = arrt_pkg::CMD_IDLE;
        w_ctl.parity = r_cnt[0];
        unique case (r_state)
            S_EXEC: begin
                priority if (r_op == arrt_pkg::OP_ADD && !w_null && !w_full) begin
                    w_ctl.cmd = arrt_pkg::CMD_ADD;
                end else if (r_op == arrt_pkg::OP_REMOVE) begin
                    w_ctl.cmd = arrt_pkg::CMD_PURGE;
                end else begin
                    w_ctl.cmd = arrt_pkg::CMD_IDLE;
                end
            end
            S_COMPACT: w_ctl.cmd = arrt_pkg::CMD_COMPACT;
            S_FIND:    w_ctl.cmd = arrt_pkg::CMD_FIND;
            default:   w_ctl.cmd = arrt_pkg::CMD_IDLE;
        endcase
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic                    w_prev_valid;
        logic                    w_next_valid;
        logic [HANDLE_BITS-1:0]  w_next_handle;
        logic [ADDRESS_BITS-1:0] w_next_base;
        logic [ADDRESS_BITS-1:0] w_next_size;
        logic                    w_next_hit;
        logic [HANDLE_BITS-1:0]  w_next_hit_handle;
        logic [ADDRESS_BITS-1:0] w_next_hit_offset;

        if (g == 0) begin : g_head
            // slot zero always has a filled slot above it
            assign w_prev_valid = 1'b1;
        end else begin : g_mid
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign w_next_valid      = 1'b0;
            assign w_next_handle     = '0;
            assign w_next_base       = '0;
            assign w_next_size       = '0;
            assign w_next_hit        = 1'b0;
            assign w_next_hit_handle = '0;
            assign w_next_hit_offset = '0;
        end else begin : g_link
            assign w_next_valid      = w_valid[g+1];
            assign w_next_handle     = w_handle[g+1];
            assign w_next_base       = w_base[g+1];
            assign w_next_size       = w_size[g+1];
            assign w_next_hit        = w_hit[g+1];
            assign w_next_hit_handle = w_hit_handle[g+1];
            assign w_next_hit_offset = w_hit_offset[g+1];
        end

        arrt_cell #(
            .ADDRESS_BITS (ADDRESS_BITS),
            .HANDLE_BITS  (HANDLE_BITS),
            .IDX_ODD      ((g % 2) == 1)
        ) u_cell (
            .i_clk             (i_clk),
            .i_rst_n           (i_rst_n),
            .i_ctl             (w_ctl),
            .i_hnd             (r_hnd),
            .i_addr            (r_addr),
            .i_len             (r_len),
            .i_prev_valid      (w_prev_valid),
            .i_next_valid      (w_next_valid),
            .i_next_handle     (w_next_handle),
            .i_next_base       (w_next_base),
            .i_next_size       (w_next_size),
            .i_next_hit        (w_next_hit),
            .i_next_hit_handle (w_next_hit_handle),
            .i_next_hit_offset (w_next_hit_offset),
            .o_valid           (w_valid[g]),
            .o_handle          (w_handle[g]),
            .o_base            (w_base[g]),
            .o_size            (w_size[g]),
            .o_hit             (w_hit[g]),
            .o_hit_handle      (w_hit_handle[g]),
            .o_hit_offset      (w_hit_offset[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            // S_RESP reloads the output register on its own
            if (r_rsp_valid && o_rsp.ready && (r_state != S_RESP)) r_rsp_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op    <= arrt_pkg::t_op'(i_req.operation);
                        r_hnd   <= i_req.handle;
                        r_addr  <= i_req.address;
                        r_len   <= i_req.length;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_cnt        <= '0;
                    r_res_handle <= '0;
                    r_res_offset <= '0;
                    unique case (r_op)
                        arrt_pkg::OP_ADD: begin
                            priority if (w_null) r_res_status <= arrt_pkg::ST_IGNORED;
                            else if (w_full)     r_res_status <= arrt_pkg::ST_FULL;
                            else                 r_res_status <= arrt_pkg::ST_OK;
                            r_state <= S_RESP;
                        end
                        arrt_pkg::OP_REMOVE: begin
                            r_res_status <= arrt_pkg::ST_OK;
                            r_state      <= S_COMPACT;
                        end
                        arrt_pkg::OP_FIND: begin
                            r_res_status <= arrt_pkg::ST_MISS;
                            r_state      <= (r_addr == '0) ? S_RESP : S_FIND;
                        end
                        default: begin
                            r_res_status <= arrt_pkg::ST_IGNORED;
                            r_state      <= S_RESP;
                        end
                    endcase
                end
                S_COMPACT: begin
                    if (r_cnt == LAST) r_state <= S_RESP;
                    else               r_cnt   <= r_cnt + 1'b1;
                end
                S_FIND: begin
                    if (r_cnt == LAST) r_state <= S_PICK;
                    else               r_cnt   <= r_cnt + 1'b1;
                end
                S_PICK: begin
                    if (w_hit[0]) begin
                        r_res_status <= arrt_pkg::ST_OK;
                        r_res_handle <= w_hit_handle[0];
                        r_res_offset <= w_hit_offset[0];
                    end
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    // hold until the output register is free
                    if (!r_rsp_valid || o_rsp.ready) begin
                        r_rsp_valid  <= 1'b1;
                        r_rsp_status <= r_res_status;
                        r_rsp_handle <= r_res_handle;
                        r_rsp_offset <= r_res_offset;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.status       = r_rsp_status;
    assign o_rsp.found_handle = r_rsp_handle;
    assign o_rsp.found_offset = r_rsp_offset;

endmodule

@@ rtl/arrt_checker.sv @@
// ----------------------------------------------------------------------------
// arrt_checker
// Port-level checks of the region table, bound to the top level.
// ----------------------------------------------------------------------------
module arrt_checker #(
    parameter int ADDRESS_BITS = arrt_pkg::ADDRESS_BITS,
    parameter int HANDLE_BITS  = arrt_pkg::HANDLE_BITS
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_req_valid,
    input logic                    i_req_ready,
    input logic                    i_rsp_valid,
    input logic                    i_rsp_ready,
    input logic [1:0]              i_rsp_status,
    input logic [HANDLE_BITS-1:0]  i_rsp_handle,
    input logic [ADDRESS_BITS-1:0] i_rsp_offset
);

    // a stalled response keeps its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_handle) && $stable(i_rsp_offset))
        else $error("response changed while stalled");

    // one request in flight: ready drops right after a request is taken
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second request taken while busy");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != arrt_pkg::ST_OK)
            |-> (i_rsp_handle == '0) && (i_rsp_offset == '0))
        else $error("non-hit response carries a handle or offset");

    // a fresh response comes only out of a busy period
    a_rsp_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> !$past(i_req_ready))
        else $error("response without a request in progress");

endmodule

bind address_range_region_table arrt_checker #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .HANDLE_BITS  (HANDLE_BITS)
) u_arrt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_handle (o_rsp.found_handle),
    .i_rsp_offset (o_rsp.found_offset)
);

@@ bench/tb_address_range_region_table.sv @@
// ----------------------------------------------------------------------------
// tb_address_range_region_table
// Drives add, remove, find and unused requests into the region table with random
// gaps and response stalls. A scoreboard keeps its own copy of the table,
// predicts each response and checks every field of what comes back.
// ----------------------------------------------------------------------------
module tb_address_range_region_table;

    localparam int TABLE_DEPTH  = arrt_pkg::TABLE_DEPTH;
    localparam int ADDRESS_BITS = arrt_pkg::ADDRESS_BITS;
    localparam int HANDLE_BITS  = arrt_pkg::HANDLE_BITS;

    localparam logic [ADDRESS_BITS-1:0] ADDR_MAX = '1;

    typedef struct {
        arrt_pkg::t_status       status;
        logic [HANDLE_BITS-1:0]  found_handle;
        logic [ADDRESS_BITS-1:0] found_offset;
    } t_region_answer;

    class t_region_scoreboard;
        logic [HANDLE_BITS-1:0]  hnd  [TABLE_DEPTH];
        logic [ADDRESS_BITS-1:0] base [TABLE_DEPTH];
        logic [ADDRESS_BITS-1:0] size [TABLE_DEPTH];
        int                      used;
        int                      peak_used;
        int                      errors;
        int                      status_count [4];
        t_region_answer          answers [$];

        function void note_request(arrt_pkg::t_op op, logic [HANDLE_BITS-1:0] h,
                                   logic [ADDRESS_BITS-1:0] a,
                                   logic [ADDRESS_BITS-1:0] l);
            t_region_answer          ans;
            logic [ADDRESS_BITS-1:0] off;
            int                      w;
            ans = '{arrt_pkg::ST_IGNORED, '0, '0};
            case (op)
                arrt_pkg::OP_ADD: begin
                    if (h == 0 || a == 0 || l == 0) begin
                        ans.status = arrt_pkg::ST_IGNORED;
                    end else if (used >= TABLE_DEPTH) begin
                        ans.status = arrt_pkg::ST_FULL;
                    end else begin
                        hnd[used]  = h;
                        base[used] = a;
                        size[used] = l;
                        used++;
                        if (used > peak_used) peak_used = used;
                        ans.status = arrt_pkg::ST_OK;
                    end
                end
                arrt_pkg::OP_REMOVE: begin
                    // close the gaps, keep insertion order
                    w = 0;
                    for (int i = 0; i < used; i++) begin
                        if (hnd[i] != h) begin
                            hnd[w]  = hnd[i];
                            base[w] = base[i];
                            size[w] = size[i];
                            w++;
                        end
                    end
                    used = w;
                    ans.status = arrt_pkg::ST_OK;
                end
                arrt_pkg::OP_FIND: begin
                    ans.status = arrt_pkg::ST_MISS;
                    if (a != 0) begin
                        for (int i = 0; i < used; i++) begin
                            if (a >= base[i]) begin
                                off = a - base[i];
                                if (off <= size[i] && l <= size[i] - off) begin
                                    ans = '{arrt_pkg::ST_OK, hnd[i], off};
                                    break;
                                end
                            end
                        end
                    end
                end
                default: ans.status = arrt_pkg::ST_IGNORED;
            endcase
            status_count[ans.status]++;
            answers.insert(answers.size(), ans);
        endfunction

        function void check_response(logic [1:0] st, logic [HANDLE_BITS-1:0] h,
                                     logic [ADDRESS_BITS-1:0] o);
            t_region_answer ans;
            if (answers.size() == 0) begin
                $error("response with no request outstanding: status %0d", st);
                errors++;
                return;
            end
            ans = answers.pop_front();
            if (st !== ans.status) begin
                $error("status: expected %0d, got %0d", ans.status, st);
                errors++;
            end
            if (h !== ans.found_handle) begin
                $error("found_handle: expected %0h, got %0h", ans.found_handle, h);
                errors++;
            end
            if (o !== ans.found_offset) begin
                $error("found_offset: expected %0h, got %0h", ans.found_offset, o);
                errors++;
            end
        endfunction

        function int pending();
            return answers.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   send_quiet;
    int   rsp_taken;

    arrt_req_if req_if ();
    arrt_rsp_if rsp_if ();

    t_region_scoreboard board = new();

    address_range_region_table i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [ADDRESS_BITS-1:0] rand_addr();
        return ADDRESS_BITS'({$urandom, $urandom});
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(arrt_pkg::t_op op, logic [HANDLE_BITS-1:0] h,
                                logic [ADDRESS_BITS-1:0] a,
                                logic [ADDRESS_BITS-1:0] l);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.handle    <= h;
        req_if.address   <= a;
        req_if.length    <= l;
        do @(posedge clk); while (!req_if.ready);
        @(negedge clk);
    endtask

    always @(posedge clk) begin
        if (rst_n && req_if.valid && req_if.ready)
            board.note_request(arrt_pkg::t_op'(req_if.operation), req_if.handle,
                               req_if.address, req_if.length);
        if (rst_n && rsp_if.valid && rsp_if.ready)
            board.check_response(rsp_if.status, rsp_if.found_handle,
                                 rsp_if.found_offset);
    end

    // response side: random stalls, one long hold-off to back up the table
    initial begin
        int stall;
        rsp_if.ready = 1'b0;
        rsp_taken = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (rsp_taken == 150)
                stall = 300;
            else if ((rsp_taken / 60) % 3 == 1)
                stall = 0;
            else
                stall = $urandom_range(0, 12);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
            rsp_taken++;
            @(negedge clk);
        end
    end

    initial begin
        arrt_pkg::t_op           op;
        logic [HANDLE_BITS-1:0]  h;
        logic [ADDRESS_BITS-1:0] a;
        logic [ADDRESS_BITS-1:0] l;
        logic [ADDRESS_BITS-1:0] off;
        logic [ADDRESS_BITS-1:0] rest;
        logic [63:0]             span;
        int                      pick;
        int                      j;
        int                      sent;

        rst_n            = 1'b0;
        send_quiet       = 1'b0;
        req_if.valid     = 1'b0;
        req_if.operation = arrt_pkg::OP_ADD;
        req_if.handle    = '0;
        req_if.address   = '0;
        req_if.length    = '0;
        sent             = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: null cases, extremes, offset equal to size, compaction
        send_request(arrt_pkg::OP_FIND,   '0,    1, '0);
        send_request(arrt_pkg::OP_UNUSED, '1,    ADDR_MAX, ADDR_MAX);
        send_request(arrt_pkg::OP_ADD,    '0,    'h100, 'h10);
        send_request(arrt_pkg::OP_ADD,    5,     '0, 'h10);
        send_request(arrt_pkg::OP_ADD,    5,     'h100, '0);
        send_request(arrt_pkg::OP_ADD,    '1,    1, ADDR_MAX);
        send_request(arrt_pkg::OP_ADD,    1,     'h1000, 'h100);
        send_request(arrt_pkg::OP_FIND,   1,     '0, '0);
        send_request(arrt_pkg::OP_FIND,   '0,    ADDR_MAX, '0);
        send_request(arrt_pkg::OP_FIND,   '0,    ADDR_MAX, 2);
        send_request(arrt_pkg::OP_FIND,   '0,    1, ADDR_MAX);
        send_request(arrt_pkg::OP_REMOVE, '1,    '0, '0);
        send_request(arrt_pkg::OP_FIND,   '0,    'h1100, '0);
        send_request(arrt_pkg::OP_FIND,   '0,    'h1100, 1);
        send_request(arrt_pkg::OP_REMOVE, '0,    '0, '0);
        send_request(arrt_pkg::OP_REMOVE, 'h1234, '0, '0);
        send_request(arrt_pkg::OP_REMOVE, 1,     '0, '0);
        for (int k = 0; k < TABLE_DEPTH; k++)
            send_request(arrt_pkg::OP_ADD, HANDLE_BITS'((k % 2) ? 3 : 2),
                         ADDRESS_BITS'('h10000 + k * 'h100), 'h1000);
        send_request(arrt_pkg::OP_ADD,    9,     'h20000, 'h10);
        send_request(arrt_pkg::OP_FIND,   '0,    'h10F00, '0);
        send_request(arrt_pkg::OP_REMOVE, 2,     '0, '0);
        send_request(arrt_pkg::OP_FIND,   '0,    'h10F00, '0);
        sent = 17 + TABLE_DEPTH + 4;

        // random: mostly well-formed traffic over a small pool of handles
        while (sent < 450) begin
            send_quiet = ((sent / 70) % 3 == 2);
            pick = $urandom_range(0, 99);
            h = ($urandom_range(0, 4) == 0) ? HANDLE_BITS'($urandom)
                                             : HANDLE_BITS'($urandom_range(1, 7));
            a = ($urandom_range(0, 1) == 0) ? rand_addr()
                                             : ADDRESS_BITS'($urandom_range(1, 1 << 20));
            l = ($urandom_range(0, 2) == 0) ? rand_addr()
                                             : ADDRESS_BITS'($urandom_range(1, 4096));
            if (pick < 40) begin
                op = arrt_pkg::OP_ADD;
                case ($urandom_range(0, 19))
                    0: h = '0;
                    1: a = '0;
                    2: l = '0;
                    default: ;
                endcase
            end else if (pick < 55) begin
                op = arrt_pkg::OP_REMOVE;
                if (board.used > 0 && $urandom_range(0, 1) == 0)
                    h = board.hnd[$urandom_range(0, board.used - 1)];
            end else if (pick < 94) begin
                op = arrt_pkg::OP_FIND;
                if (board.used > 0 && $urandom_range(0, 4) != 0) begin
                    j    = $urandom_range(0, board.used - 1);
                    span = {16'd0, board.size[j]} + 64'd1;
                    case ($urandom_range(0, 3))
                        0:       off = '0;
                        1:       off = board.size[j];
                        default: off = ADDRESS_BITS'({$urandom, $urandom} % span);
                    endcase
                    rest = board.size[j] - off;
                    a    = board.base[j] + off;
                    case ($urandom_range(0, 3))
                        0:       l = '0;
                        1:       l = rest;
                        2:       l = (rest == ADDR_MAX) ? rest : rest + 1'b1;
                        default: l = ADDRESS_BITS'({$urandom, $urandom}
                                                   % ({16'd0, rest} + 64'd1));
                    endcase
                end else if ($urandom_range(0, 3) == 0) begin
                    a = '0;
                end
            end else begin
                op = arrt_pkg::OP_UNUSED;
                a  = rand_addr();
            end
            send_request(op, h, a, l);
            sent++;
        end
        req_if.valid <= 1'b0;

        while (board.pending() != 0) @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);

        $display("Ran %0d requests, %0d responses; table peaked at %0d of %0d regions.",
                 sent, rsp_taken, board.peak_used, TABLE_DEPTH);
        $display("Responses: %0d done/hit, %0d miss, %0d ignored, %0d full.",
                 board.status_count[arrt_pkg::ST_OK], board.status_count[arrt_pkg::ST_MISS],
                 board.status_count[arrt_pkg::ST_IGNORED],
                 board.status_count[arrt_pkg::ST_FULL]);
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
